// ===== hdl/sdcwb_pkg.sv =====
// sdcwb_pkg.sv: shared types, codes and constants of the sd host command word builder
`timescale 1ns / 1ps

package sdcwb_pkg;

  // struct widths, and beat widths padded to whole bytes
  localparam int REQ_BITS   = 104;
  localparam int RES_BITS   = 115;
  localparam int S_DATA_W   = 104;
  localparam int M_DATA_W   = 120;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_RESP  = 2'd1;
  localparam logic [1:0] ST_PARTIAL   = 2'd2;
  localparam logic [1:0] ST_TOO_MANY  = 2'd3;

  // response length codes (command plus response bytes)
  localparam logic [7:0] RLEN_NONE    = 8'd8;
  localparam logic [7:0] RLEN_48      = 8'd12;
  localparam logic [7:0] RLEN_136     = 8'd23;

  // response type field
  localparam logic [1:0] RSP_NONE     = 2'd0;
  localparam logic [1:0] RSP_136      = 2'd1;
  localparam logic [1:0] RSP_48       = 2'd2;
  localparam logic [1:0] RSP_48_BUSY  = 2'd3;

  // command type field
  localparam logic [1:0] TYPE_NORMAL  = 2'd0;
  localparam logic [1:0] TYPE_SUSPEND = 2'd1;
  localparam logic [1:0] TYPE_RESUME  = 2'd2;
  localparam logic [1:0] TYPE_ABORT   = 2'd3;

  // command indexes that change the command type
  localparam logic [5:0] CMD_STOP     = 6'd12;
  localparam logic [5:0] CMD_IO_RW    = 6'd52;

  // function-0 register addresses for io direct writes
  localparam logic [16:0] REG_ABORT   = 17'h00006;
  localparam logic [16:0] REG_SUSPEND = 17'h0000C;
  localparam logic [16:0] REG_SELECT  = 17'h0000D;

  // app command prefix word
  localparam logic [15:0] PREFIX_WORD = 16'h371A;

  // request beat, last member in the lowest bits
  typedef struct packed {
    logic [15:0] card_rca;
    logic        auto_stop;
    logic        dir_read;
    logic [3:0]  split_log2;
    logic [31:0] data_length;
    logic [31:0] cmd_argument;
    logic [7:0]  resp_len;
    logic        check_busy;
    logic        check_index;
    logic        check_crc;
    logic        app_cmd;
    logic [5:0]  cmd_index;
  } req_t;

  // result beat, last member in the lowest bits
  typedef struct packed {
    logic [31:0] prefix_argument;
    logic [15:0] prefix_command;
    logic        prefix_needed;
    logic [15:0] blk_count;
    logic [15:0] blk_size;
    logic [15:0] xfer_mode;
    logic [15:0] command_word;
    logic [1:0]  status;
  } res_t;

endpackage

// ===== hdl/sdcwb_encode.sv =====
// sdcwb_encode.sv: single-pass decode of one request into host controller words
`timescale 1ns / 1ps

module sdcwb_encode
  import sdcwb_pkg::*;
(
  input  req_t req,
  output res_t res
);

  logic        rsp_ok;
  logic [1:0]  rsp;
  logic [1:0]  cmd_type;
  logic [16:0] io_reg;
  logic        io_write_f0;
  logic        len_small;
  logic        partial;
  logic        too_many;
  logic [31:0] blk_quot;
  logic [31:0] blk_mask;
  logic [15:0] bsize;
  logic [15:0] bcount;
  logic        multi;
  logic [15:0] cw;
  logic [15:0] xm;

  // response type from the length
  always_comb begin
    rsp_ok = 1'b1;
    rsp    = RSP_NONE;
    priority if (req.resp_len == RLEN_NONE) begin
      rsp = RSP_NONE;
    end else if (req.resp_len == RLEN_136) begin
      rsp = RSP_136;
    end else if (req.resp_len == RLEN_48) begin
      rsp = req.check_busy ? RSP_48_BUSY : RSP_48;
    end else begin
      rsp_ok = 1'b0;
    end
  end

  // command type: stop, or io direct write to a function-0 control register
  assign io_reg      = req.cmd_argument[25:9];
  assign io_write_f0 = req.cmd_argument[31] && (req.cmd_argument[30:28] == 3'd0);

  always_comb begin
    cmd_type = TYPE_NORMAL;
    if (!req.app_cmd) begin
      if (req.cmd_index == CMD_STOP) begin
        cmd_type = TYPE_ABORT;
      end else if (req.cmd_index == CMD_IO_RW && io_write_f0) begin
        unique case (io_reg)
          REG_ABORT:   cmd_type = TYPE_ABORT;
          REG_SUSPEND: cmd_type = TYPE_SUSPEND;
          REG_SELECT:  cmd_type = TYPE_RESUME;
          default:     cmd_type = TYPE_NORMAL;
        endcase
      end
    end
  end

  // block split: split size is a power of two, so the count is a shift
  assign blk_quot  = req.data_length >> req.split_log2;
  assign blk_mask  = ~(32'hFFFF_FFFF << req.split_log2);
  assign len_small = (blk_quot == 32'd0);
  assign partial   = !len_small && ((req.data_length & blk_mask) != 32'd0);
  assign too_many  = !len_small && (blk_quot[31:16] != 16'd0);

  always_comb begin
    if (len_small) begin
      bsize  = req.data_length[15:0];
      bcount = {15'd0, (req.data_length != 32'd0)};
    end else begin
      bsize  = 16'd1 << req.split_log2;
      bcount = blk_quot[15:0];
    end
  end

  assign multi = (bcount > 16'd1);

  // register images
  assign cw = {2'b00, req.cmd_index, cmd_type, (req.data_length != 32'd0),
               req.check_index, req.check_crc, 1'b0, rsp};
  assign xm = {10'd0, multi, req.dir_read, 1'b0, req.auto_stop, multi, 1'b0};

  // status with precedence, zero fields on any error
  always_comb begin
    res = '0;
    priority if (!rsp_ok) begin
      res.status = ST_BAD_RESP;
    end else if (partial) begin
      res.status = ST_PARTIAL;
    end else if (too_many) begin
      res.status = ST_TOO_MANY;
    end else begin
      res.status       = ST_OK;
      res.command_word = cw;
      res.xfer_mode    = xm;
      res.blk_size     = bsize;
      res.blk_count    = bcount;
      if (req.app_cmd) begin
        res.prefix_needed   = 1'b1;
        res.prefix_command  = PREFIX_WORD;
        res.prefix_argument = {req.card_rca, 16'd0};
      end
    end
  end

endmodule

// ===== hdl/sd_host_command_word_builder_unit.sv =====
// sd_host_command_word_builder_unit.sv: top level of the sd host command word builder
`timescale 1ns / 1ps
// Turns one SD/SDIO request beat into host controller command word, transfer
// mode, block size, block count and the CMD55 prefix for app commands.
// Input channel s_*: one request per beat. Output channel m_*: one result per
// beat, in request order, exactly one result for each request.
// Stages: two register stages, request register then result register.
// Throughput: one request per cycle unless m_tready stalls the output; the decode
// is a single shallow pass, the block count is a shift by the split exponent.
// Stall: when m_tready is low the result register holds; the request register
// still fills, so s_tready drops only when both stages are full.
// Reset: rst (synchronous, active high) empties both stages; no result beats
// are pending afterwards. There is no configuration.
// Status 1, 2 and 3 report a bad response length, a partial last block and
// a block count of 65536 or more; all other result fields are then zero.

module sd_host_command_word_builder_unit
  import sdcwb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // s_tdata: cmd_index, app_cmd, check_crc, check_index, check_busy, resp_len,
  // cmd_argument, data_length, split_log2, dir_read, auto_stop, card_rca
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,
  // m_tdata: status, command_word, xfer_mode, blk_size, blk_count,
  // prefix_needed, prefix_command, prefix_argument, then zero pad
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata
);

  logic req_valid;
  req_t req;
  logic res_valid;
  res_t res;
  res_t res_next;
  logic res_load;
  logic req_load;

  // stage handshake
  assign res_load = !res_valid || m_tready;
  assign s_tready = !req_valid || res_load;
  assign req_load = s_tvalid && s_tready;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_tready) begin
      req_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_load) begin
      req <= req_t'(s_tdata[REQ_BITS-1:0]);
    end
  end

  // decode
  sdcwb_encode u_encode (
    .req (req),
    .res (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load && req_valid) begin
      res <= res_next;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {(M_DATA_W-RES_BITS)'(0), res};

endmodule

// ===== hdl/sdcwb_check.sv =====
// sdcwb_check.sv: port-level assertions for the command word builder, bound to the top
`timescale 1ns / 1ps

module sdcwb_check
  import sdcwb_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  // a stalled result beat stays and holds its payload
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // nothing is pending right after reset
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result beat present after reset");

  // an error beat carries only its status
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[M_DATA_W-1:2] == '0))
    else $error("error beat has nonzero fields");

  // prefix fields are zero unless a prefix is needed
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[66] |-> (m_tdata[114:67] == '0))
    else $error("prefix fields set without prefix flag");

  // multi-block transfers set the multi-block and count enable bits
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[65:50] > 16'd1) |-> m_tdata[23] && m_tdata[19])
    else $error("multi-block bits missing");

endmodule

bind sd_host_command_word_builder_unit sdcwb_check u_sdcwb_check (.*);

// ===== bench/tb.sv =====
// tb.sv: self-checking bench for the sd host command word builder unit
`timescale 1ns / 1ps

module tb;
  import sdcwb_pkg::*;

  localparam int STUCK_LIMIT = 5000;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 10;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  // encoded words still owed by the block, oldest first
  res_t words_due[$];
  int   errors = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  bit   hold_req = 1'b0;
  int   stuck_cycles = 0;

  sd_host_command_word_builder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // expected host controller words for one request
  function automatic res_t encode_request(input req_t r);
    res_t        o;
    logic [1:0]  rsp;
    logic [1:0]  ctype;
    logic [16:0] reg_addr;
    logic [31:0] split;
    logic [31:0] bsize;
    logic [31:0] bcount;
    logic        multi;
    o = '0;
    rsp = RSP_NONE;
    case (r.resp_len)
      RLEN_NONE: rsp = RSP_NONE;
      RLEN_136:  rsp = RSP_136;
      RLEN_48:   rsp = r.check_busy ? RSP_48_BUSY : RSP_48;
      default: begin
        o.status = ST_BAD_RESP;
        return o;
      end
    endcase
    // stop and io direct writes to abort, suspend, select change the type
    ctype = TYPE_NORMAL;
    reg_addr = r.cmd_argument[25:9];
    if (!r.app_cmd) begin
      if (r.cmd_index == CMD_STOP) begin
        ctype = TYPE_ABORT;
      end else if (r.cmd_index == CMD_IO_RW && r.cmd_argument[31] &&
                   r.cmd_argument[30:28] == 3'b000) begin
        if (reg_addr == REG_ABORT) ctype = TYPE_ABORT;
        else if (reg_addr == REG_SUSPEND) ctype = TYPE_SUSPEND;
        else if (reg_addr == REG_SELECT) ctype = TYPE_RESUME;
      end
    end
    // cut the data into blocks of at most the split size
    split = 32'd1 << r.split_log2;
    bsize = (r.data_length < split) ? r.data_length : split;
    bcount = '0;
    if (bsize != 0) begin
      if (r.data_length % bsize != 0) begin
        o.status = ST_PARTIAL;
        return o;
      end
      bcount = r.data_length / bsize;
      if (bcount >= 32'h10000) begin
        o.status = ST_TOO_MANY;
        return o;
      end
    end
    multi = (bcount > 1);
    o.status = ST_OK;
    o.command_word = {2'b00, r.cmd_index, ctype, r.data_length != 0,
                      r.check_index, r.check_crc, 1'b0, rsp};
    o.xfer_mode = {10'b0, multi, r.dir_read, 1'b0, r.auto_stop, multi, 1'b0};
    o.blk_size = bsize[15:0];
    o.blk_count = bcount[15:0];
    if (r.app_cmd) begin
      o.prefix_needed = 1'b1;
      o.prefix_command = PREFIX_WORD;
      o.prefix_argument = {r.card_rca, 16'h0000};
    end
    return o;
  endfunction

  // quiet request with the given index and response length
  function automatic req_t base_req(input logic [5:0] idx, input logic [7:0] rlen);
    req_t r;
    r = '0;
    r.cmd_index = idx;
    r.resp_len = rlen;
    return r;
  endfunction

  // mostly well-formed requests, with some garbage lengths and arguments
  function automatic req_t random_request();
    req_t        r;
    int          pick;
    logic [47:0] len_wide;
    logic [16:0] reg_addr;
    r = '0;
    pick = $urandom_range(99);
    r.cmd_index = (pick < 20) ? CMD_STOP : (pick < 45) ? CMD_IO_RW : 6'($urandom);
    r.app_cmd = $urandom_range(3) == 0;
    r.check_crc = 1'($urandom_range(1));
    r.check_index = 1'($urandom_range(1));
    r.check_busy = 1'($urandom_range(1));
    if ($urandom_range(99) < 85) begin
      case ($urandom_range(2))
        0: r.resp_len = RLEN_NONE;
        1: r.resp_len = RLEN_48;
        default: r.resp_len = RLEN_136;
      endcase
    end else begin
      r.resp_len = 8'($urandom);
    end
    // io direct write form with a function-0 register, or anything
    if ($urandom_range(99) < 40) begin
      case ($urandom_range(3))
        0: reg_addr = REG_ABORT;
        1: reg_addr = REG_SUSPEND;
        2: reg_addr = REG_SELECT;
        default: reg_addr = 17'($urandom);
      endcase
      r.cmd_argument = {($urandom_range(9) != 0),
                        ($urandom_range(9) == 0) ? 3'($urandom) : 3'b000,
                        2'($urandom), reg_addr, 9'($urandom)};
    end else begin
      r.cmd_argument = $urandom;
    end
    r.split_log2 = 4'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 10) begin
      r.data_length = '0;
    end else if (pick < 60) begin
      len_wide = 48'($urandom_range(1, 8)) << r.split_log2;
      r.data_length = len_wide[31:0];
    end else if (pick < 70) begin
      len_wide = 48'($urandom_range(65530, 65540)) << r.split_log2;
      r.data_length = len_wide[31:0];
    end else if (pick < 80) begin
      r.data_length = $urandom_range(1, 32'd1 << r.split_log2);
    end else begin
      r.data_length = $urandom;
    end
    r.dir_read = 1'($urandom_range(1));
    r.auto_stop = 1'($urandom_range(1));
    r.card_rca = 16'($urandom);
    return r;
  endfunction

  // offer one request beat, with random gaps ahead of it
  task automatic offer_request(input req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata <= S_DATA_W'({$urandom, $urandom, $urandom, $urandom});
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= r;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_due.push_back(encode_request(r));
  endtask

  // stop offering and wait for every owed word
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (words_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_response_types();
    req_t r;
    r = base_req(6'd0, RLEN_NONE);
    offer_request(r);
    r.resp_len = RLEN_48;
    r.check_crc = 1'b1;
    r.check_index = 1'b1;
    offer_request(r);
    r.check_busy = 1'b1;
    offer_request(r);
    r.resp_len = RLEN_136;
    offer_request(r);
    r.resp_len = 8'd0;
    offer_request(r);
    r.resp_len = 8'hFF;
    offer_request(r);
    r.resp_len = 8'd13;
    offer_request(r);
  endtask

  task automatic test_command_types();
    req_t r;
    // stop is an abort unless it is an app command
    r = base_req(CMD_STOP, RLEN_48);
    r.check_busy = 1'b1;
    offer_request(r);
    r.app_cmd = 1'b1;
    offer_request(r);
    // io direct writes to function-0 abort, suspend and select
    r = base_req(CMD_IO_RW, RLEN_48);
    r.cmd_argument = {1'b1, 3'b000, 2'b00, REG_ABORT, 9'h1FF};
    offer_request(r);
    r.cmd_argument = {1'b1, 3'b000, 2'b11, REG_SUSPEND, 9'h000};
    offer_request(r);
    r.cmd_argument = {1'b1, 3'b000, 2'b00, REG_SELECT, 9'h0A5};
    offer_request(r);
    // other function or a read leaves the type normal
    r.cmd_argument = {1'b1, 3'b100, 2'b00, REG_ABORT, 9'h000};
    offer_request(r);
    r.cmd_argument = {1'b0, 3'b000, 2'b00, REG_ABORT, 9'h000};
    offer_request(r);
    r.cmd_argument = {1'b1, 3'b000, 2'b00, REG_ABORT, 9'h000};
    r.app_cmd = 1'b1;
    offer_request(r);
    r = base_req(6'd63, RLEN_136);
    r.cmd_argument = 32'hFFFF_FFFF;
    offer_request(r);
  endtask

  task automatic test_block_split();
    req_t r;
    // length below the split size is one block
    r = base_req(6'd17, RLEN_48);
    r.data_length = 32'd100;
    r.split_log2 = 4'd9;
    offer_request(r);
    r.data_length = 32'd4096;
    r.dir_read = 1'b1;
    offer_request(r);
    // partial last block
    r.data_length = 32'd1000;
    offer_request(r);
    // too many blocks, then the largest legal count and block
    r.data_length = 32'h0001_0000;
    r.split_log2 = 4'd0;
    offer_request(r);
    r.data_length = 32'h7FFF_8000;
    r.split_log2 = 4'd15;
    offer_request(r);
    r.data_length = 32'hFFFF_FFFF;
    offer_request(r);
    r.data_length = 32'd32768;
    r.auto_stop = 1'b1;
    offer_request(r);
  endtask

  task automatic test_app_prefix();
    req_t r;
    r = base_req(6'd41, RLEN_48);
    r.app_cmd = 1'b1;
    r.card_rca = 16'hFFFF;
    r.data_length = 32'd512;
    r.split_log2 = 4'd9;
    r.check_crc = 1'b1;
    offer_request(r);
    // no data, direction and auto stop still pass through
    r = base_req(6'd6, RLEN_NONE);
    r.app_cmd = 1'b1;
    r.card_rca = 16'h1234;
    r.dir_read = 1'b1;
    r.auto_stop = 1'b1;
    offer_request(r);
  endtask

  // receiver holds off while requests keep coming, then the sender pauses
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    repeat (16) offer_request(random_request());
    drain();
    repeat (8) offer_request(random_request());
  endtask

  task automatic test_random(input int count, input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) offer_request(random_request());
  endtask

  // receiver ready, random or held off for a long stretch
  always @(posedge clk) begin : result_sink
    int hold_left;
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // compare each result beat with the oldest owed word
  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[RES_BITS-1:0];
      if (words_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual 0x%0h", $time, got);
      end else begin
        want = words_due.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("command_word", 32'(want.command_word), 32'(got.command_word));
        check_field("xfer_mode", 32'(want.xfer_mode), 32'(got.xfer_mode));
        check_field("blk_size", 32'(want.blk_size), 32'(got.blk_size));
        check_field("blk_count", 32'(want.blk_count), 32'(got.blk_count));
        check_field("prefix_needed", 32'(want.prefix_needed), 32'(got.prefix_needed));
        check_field("prefix_command", 32'(want.prefix_command),
                    32'(got.prefix_command));
        check_field("prefix_argument", want.prefix_argument, got.prefix_argument);
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_response_types();
    test_command_types();
    test_block_split();
    test_app_prefix();
    test_backpressure();
    test_random(140, 25, 45);
    test_random(130, 45, 25);
    test_random(130, 0, 0);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sd_host_command_word_builder_unit.f =====
hdl/sdcwb_pkg.sv
hdl/sdcwb_encode.sv
hdl/sd_host_command_word_builder_unit.sv
hdl/sdcwb_check.sv
bench/tb.sv
